// File: hw/rtl/dci_pkg.sv
// Shared types and constants for the disk collision impulse block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dci_pkg;

  localparam int VEL_W   = 16;
  localparam int POS_W   = 16;
  localparam int RAD_W   = 15;
  localparam int MASS_W  = 16;
  localparam int CFG_W   = 16;
  localparam int DIFF_W  = 17;
  localparam int PROD_W  = 34;
  localparam int DOT_W   = 35;
  localparam int MAG_W   = 34;
  localparam int RS_W    = 16;
  localparam int RS2_W   = 32;
  localparam int DIST_W  = 32;
  localparam int MSUM_W  = 17;
  localparam int ONEE_W  = 17;
  localparam int KMAG_W  = 51;
  localparam int DEN_W   = 49;
  localparam int MP_W    = 32;
  localparam int KLO_W   = 26;
  localparam int KHI_W   = KMAG_W - KLO_W;
  localparam int PLO_W   = KLO_W + MP_W;
  localparam int PHI_W   = KHI_W + MP_W;
  localparam int NUM_W   = 84;
  localparam int DV_W    = 64;
  localparam int REM_W   = 86;
  localparam int QBITS   = 21;
  localparam int SUM_W   = 23;
  localparam int LANES   = 4;

  localparam logic [CFG_W-1:0]  RESTITUTION_RESET = 16'd29491;
  localparam logic [ONEE_W-1:0] ONE_Q15 = 17'd32768;
  localparam logic [QBITS-1:0]  DELTA_CAP = 21'd1048576;

  localparam int MID_DEPTH = 8;
  localparam int MID_AW    = 3;
  localparam int MID_CW    = 4;
  localparam int OUT_DEPTH = 32;
  localparam int OUT_AW    = 5;
  localparam int OUT_CW    = 6;

  typedef enum logic [1:0] {
    OUT_NONE       = 2'd0,
    OUT_SEPARATING = 2'd1,
    OUT_IMPULSE    = 2'd2,
    OUT_COINCIDENT = 2'd3
  } outcome_t;

  typedef struct packed {
    outcome_t                   outcome;
    logic                       apply;
    logic signed [VEL_W-1:0]    avx;
    logic signed [VEL_W-1:0]    avy;
    logic signed [VEL_W-1:0]    bvx;
    logic signed [VEL_W-1:0]    bvy;
    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dy;
    logic [MAG_W-1:0]           dot_mag;
    logic [DIST_W-1:0]          dist2;
    logic [MASS_W-1:0]          am;
    logic [MASS_W-1:0]          bm;
  } mid_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] avx;
    logic signed [VEL_W-1:0] avy;
    logic signed [VEL_W-1:0] bvx;
    logic signed [VEL_W-1:0] bvy;
    outcome_t                outcome;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/dci_front.sv
// Front end: takes a disk pair, forms differences and products, classifies contact.
// Depends on dci_pkg.
`default_nettype none

module dci_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [dci_pkg::POS_W-1:0]     a_pos_x,
  input  logic signed [dci_pkg::POS_W-1:0]     a_pos_y,
  input  logic signed [dci_pkg::VEL_W-1:0]     a_vel_x,
  input  logic signed [dci_pkg::VEL_W-1:0]     a_vel_y,
  input  logic [dci_pkg::RAD_W-1:0]            a_radius,
  input  logic [dci_pkg::MASS_W-1:0]           a_mass,
  input  logic signed [dci_pkg::POS_W-1:0]     b_pos_x,
  input  logic signed [dci_pkg::POS_W-1:0]     b_pos_y,
  input  logic signed [dci_pkg::VEL_W-1:0]     b_vel_x,
  input  logic signed [dci_pkg::VEL_W-1:0]     b_vel_y,
  input  logic [dci_pkg::RAD_W-1:0]            b_radius,
  input  logic [dci_pkg::MASS_W-1:0]           b_mass,
  output logic                                 out_valid,
  output dci_pkg::mid_t                        out_item
);

  logic                                v1, v2;
  logic signed [dci_pkg::DIFF_W-1:0]   dx1, dy1, dvx1, dvy1, dx2, dy2;
  logic [dci_pkg::RS_W-1:0]            rs1;
  logic [dci_pkg::MASS_W-1:0]          am1, bm1, am2, bm2;
  logic signed [dci_pkg::VEL_W-1:0]    avx1, avy1, bvx1, bvy1, avx2, avy2, bvx2, bvy2;
  logic signed [dci_pkg::PROD_W-1:0]   ddx2, ddy2, dtx2, dty2;
  logic [dci_pkg::RS2_W-1:0]           rs2_2;
  logic [dci_pkg::PROD_W-1:0]          dist2;
  logic signed [dci_pkg::DOT_W-1:0]    dot;
  logic                                overlap;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    dx1  <= dci_pkg::DIFF_W'(b_pos_x) - dci_pkg::DIFF_W'(a_pos_x);
    dy1  <= dci_pkg::DIFF_W'(b_pos_y) - dci_pkg::DIFF_W'(a_pos_y);
    dvx1 <= dci_pkg::DIFF_W'(b_vel_x) - dci_pkg::DIFF_W'(a_vel_x);
    dvy1 <= dci_pkg::DIFF_W'(b_vel_y) - dci_pkg::DIFF_W'(a_vel_y);
    rs1  <= dci_pkg::RS_W'(a_radius) + dci_pkg::RS_W'(b_radius);
    // zero mass counts as one LSB
    am1  <= (a_mass == '0) ? dci_pkg::MASS_W'(1) : a_mass;
    bm1  <= (b_mass == '0) ? dci_pkg::MASS_W'(1) : b_mass;
    avx1 <= a_vel_x;
    avy1 <= a_vel_y;
    bvx1 <= b_vel_x;
    bvy1 <= b_vel_y;

    ddx2  <= dx1 * dx1;
    ddy2  <= dy1 * dy1;
    dtx2  <= dvx1 * dx1;
    dty2  <= dvy1 * dy1;
    rs2_2 <= rs1 * rs1;
    dx2   <= dx1;
    dy2   <= dy1;
    am2   <= am1;
    bm2   <= bm1;
    avx2  <= avx1;
    avy2  <= avy1;
    bvx2  <= bvx1;
    bvy2  <= bvy1;
  end

  assign dist2   = ddx2 + ddy2;
  assign dot     = dci_pkg::DOT_W'(dtx2) + dci_pkg::DOT_W'(dty2);
  assign overlap = dist2 < dci_pkg::PROD_W'(rs2_2);

  always_comb begin
    out_item.apply = 1'b0;
    if (!overlap) begin
      out_item.outcome = dci_pkg::OUT_NONE;
    end else if (dist2 == '0) begin
      out_item.outcome = dci_pkg::OUT_COINCIDENT;
    end else if (dot > 0) begin
      out_item.outcome = dci_pkg::OUT_SEPARATING;
    end else begin
      out_item.outcome = dci_pkg::OUT_IMPULSE;
      out_item.apply   = (dot != '0);
    end
    out_item.avx     = avx2;
    out_item.avy     = avy2;
    out_item.bvx     = bvx2;
    out_item.bvy     = bvy2;
    out_item.dx      = dx2;
    out_item.dy      = dy2;
    out_item.dot_mag = dci_pkg::MAG_W'(-dot);
    out_item.dist2   = dist2[dci_pkg::DIST_W-1:0];
    out_item.am      = am2;
    out_item.bm      = bm2;
  end

  assign out_valid = v2;

endmodule

`default_nettype wire

// File: hw/rtl/dci_queue.sv
// Short queue between the front and back ends of the collision block.
// Depends on dci_pkg.
`default_nettype none

module dci_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  dci_pkg::mid_t                 push_item,
  input  logic                          pop,
  output logic                          valid,
  output dci_pkg::mid_t                 head
);

  dci_pkg::mid_t                mem [dci_pkg::MID_DEPTH];
  logic [dci_pkg::MID_AW-1:0]   wr_ptr, rd_ptr;
  logic [dci_pkg::MID_CW-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

endmodule

`default_nettype wire

// File: hw/rtl/dci_back.sv
// Back end: impulse products, pipelined restoring divide per component,
// rounding, saturation and the result queue. Depends on dci_pkg.
`default_nettype none

module dci_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  dci_pkg::mid_t                 in_item,
  input  logic [dci_pkg::CFG_W-1:0]     restitution,
  input  logic                          pop,
  output logic                          empty,
  output dci_pkg::result_t              head
);

  typedef struct packed {
    dci_pkg::outcome_t                                        outcome;
    logic                                                     apply;
    logic [dci_pkg::LANES-1:0][dci_pkg::VEL_W-1:0]            vel;
    logic [dci_pkg::LANES-1:0]                                neg;
    logic [dci_pkg::LANES-1:0]                                over;
    logic [dci_pkg::LANES-1:0][dci_pkg::REM_W-1:0]            rem;
    logic [dci_pkg::LANES-1:0][dci_pkg::QBITS-1:0]            q;
    logic [dci_pkg::DV_W-1:0]                                 dv;
  } div_t;

  // product stages
  logic                                                 v1, v2, v3;
  logic [dci_pkg::KMAG_W-1:0]                           kmag1;
  logic [dci_pkg::DEN_W-1:0]                            den1, den2, den3;
  logic [dci_pkg::LANES-1:0][dci_pkg::MP_W-1:0]         mp1;
  logic [dci_pkg::LANES-1:0][dci_pkg::PLO_W-1:0]        plo2;
  logic [dci_pkg::LANES-1:0][dci_pkg::PHI_W-1:0]        phi2;
  logic [dci_pkg::LANES-1:0][dci_pkg::NUM_W-1:0]        num3;
  logic [dci_pkg::LANES-1:0][dci_pkg::VEL_W-1:0]        vel1, vel2, vel3;
  logic [dci_pkg::LANES-1:0]                            neg1, neg2, neg3;
  dci_pkg::outcome_t                                    oc1, oc2, oc3;
  logic                                                 ap1, ap2, ap3;
  logic [dci_pkg::VEL_W-1:0]                            dxm, dym;
  logic [dci_pkg::ONEE_W-1:0]                           one_e;
  logic [dci_pkg::MSUM_W-1:0]                           msum;

  div_t                                                 st [dci_pkg::QBITS+1];
  logic [dci_pkg::QBITS:0]                              st_v;

  assign dxm   = in_item.dx[dci_pkg::DIFF_W-1] ? dci_pkg::VEL_W'(-in_item.dx)
                                               : dci_pkg::VEL_W'(in_item.dx);
  assign dym   = in_item.dy[dci_pkg::DIFF_W-1] ? dci_pkg::VEL_W'(-in_item.dy)
                                               : dci_pkg::VEL_W'(in_item.dy);
  assign one_e = dci_pkg::ONE_Q15 + dci_pkg::ONEE_W'(restitution);
  assign msum  = dci_pkg::MSUM_W'(in_item.am) + dci_pkg::MSUM_W'(in_item.bm);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      st_v <= '0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      st_v <= {st_v[dci_pkg::QBITS-1:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    kmag1  <= dci_pkg::KMAG_W'(in_item.dot_mag) * dci_pkg::KMAG_W'(one_e);
    den1   <= dci_pkg::DEN_W'(in_item.dist2) * dci_pkg::DEN_W'(msum);
    // lanes: A x, A y, B x, B y; A moves against d, B along it
    mp1[0] <= dci_pkg::MP_W'(dxm) * dci_pkg::MP_W'(in_item.bm);
    mp1[1] <= dci_pkg::MP_W'(dym) * dci_pkg::MP_W'(in_item.bm);
    mp1[2] <= dci_pkg::MP_W'(dxm) * dci_pkg::MP_W'(in_item.am);
    mp1[3] <= dci_pkg::MP_W'(dym) * dci_pkg::MP_W'(in_item.am);
    neg1   <= {in_item.dy[dci_pkg::DIFF_W-1], in_item.dx[dci_pkg::DIFF_W-1],
               ~in_item.dy[dci_pkg::DIFF_W-1], ~in_item.dx[dci_pkg::DIFF_W-1]};
    vel1   <= {in_item.bvy, in_item.bvx, in_item.avy, in_item.avx};
    oc1    <= in_item.outcome;
    ap1    <= in_item.apply;

    for (int l = 0; l < dci_pkg::LANES; l++) begin
      plo2[l] <= dci_pkg::PLO_W'(kmag1[dci_pkg::KLO_W-1:0]) * dci_pkg::PLO_W'(mp1[l]);
      phi2[l] <= dci_pkg::PHI_W'(kmag1[dci_pkg::KMAG_W-1:dci_pkg::KLO_W])
                 * dci_pkg::PHI_W'(mp1[l]);
      // add half the divisor for round to nearest
      num3[l] <= dci_pkg::NUM_W'(plo2[l])
                 + (dci_pkg::NUM_W'(phi2[l]) << dci_pkg::KLO_W)
                 + (dci_pkg::NUM_W'(den2) << 14);
    end
    den2 <= den1;
    den3 <= den2;
    neg2 <= neg1;
    neg3 <= neg2;
    vel2 <= vel1;
    vel3 <= vel2;
    oc2  <= oc1;
    oc3  <= oc2;
    ap2  <= ap1;
    ap3  <= ap2;
  end

  // overflow check ahead of the bit stages
  always_ff @(posedge clk) begin
    st[0].outcome <= oc3;
    st[0].apply   <= ap3;
    st[0].vel     <= vel3;
    st[0].neg     <= neg3;
    st[0].dv      <= dci_pkg::DV_W'(den3) << 15;
    for (int l = 0; l < dci_pkg::LANES; l++) begin
      st[0].over[l] <= dci_pkg::REM_W'(num3[l])
                       >= (dci_pkg::REM_W'(dci_pkg::DV_W'(den3) << 15) << dci_pkg::QBITS);
      st[0].rem[l]  <= dci_pkg::REM_W'(num3[l]);
      st[0].q[l]    <= '0;
    end
  end

  for (genvar k = 1; k <= dci_pkg::QBITS; k++) begin : g_div
    localparam int BIT = dci_pkg::QBITS - k;
    logic [dci_pkg::REM_W-1:0] shifted;
    assign shifted = dci_pkg::REM_W'(st[k-1].dv) << BIT;

    always_ff @(posedge clk) begin
      st[k] <= st[k-1];
      for (int l = 0; l < dci_pkg::LANES; l++) begin
        if (st[k-1].rem[l] >= shifted) begin
          st[k].rem[l]    <= st[k-1].rem[l] - shifted;
          st[k].q[l][BIT] <= 1'b1;
        end
      end
    end
  end

  // cap, apply sign, add and saturate; velocity passes unchanged when apply is low
  logic [dci_pkg::LANES-1:0][dci_pkg::VEL_W-1:0] new_vel;

  always_comb begin
    logic [dci_pkg::QBITS-1:0]   mag;
    logic signed [dci_pkg::SUM_W-1:0] dm, sum;
    for (int l = 0; l < dci_pkg::LANES; l++) begin
      mag = (st[dci_pkg::QBITS].over[l] || st[dci_pkg::QBITS].q[l] > dci_pkg::DELTA_CAP)
            ? dci_pkg::DELTA_CAP : st[dci_pkg::QBITS].q[l];
      dm  = st[dci_pkg::QBITS].neg[l] ? -$signed(dci_pkg::SUM_W'(mag))
                                      : $signed(dci_pkg::SUM_W'(mag));
      sum = dci_pkg::SUM_W'($signed(st[dci_pkg::QBITS].vel[l])) + dm;
      if (!st[dci_pkg::QBITS].apply) begin
        new_vel[l] = st[dci_pkg::QBITS].vel[l];
      end else if (sum > 32767) begin
        new_vel[l] = 16'h7fff;
      end else if (sum < -32768) begin
        new_vel[l] = 16'h8000;
      end else begin
        new_vel[l] = sum[dci_pkg::VEL_W-1:0];
      end
    end
  end

  // result queue
  dci_pkg::result_t              mem [dci_pkg::OUT_DEPTH];
  dci_pkg::result_t              wr_item;
  logic [dci_pkg::OUT_AW-1:0]    wr_ptr, rd_ptr;
  logic [dci_pkg::OUT_CW-1:0]    count;
  logic                          wr, rd;

  assign wr = st_v[dci_pkg::QBITS];
  assign rd = pop && !empty;

  always_comb begin
    wr_item.avx     = new_vel[0];
    wr_item.avy     = new_vel[1];
    wr_item.bvx     = new_vel[2];
    wr_item.bvy     = new_vel[3];
    wr_item.outcome = st[dci_pkg::QBITS].outcome;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

endmodule

`default_nettype wire

// File: hw/rtl/disk_collision_impulse.sv
// Top level of the disk collision impulse block: front end, queue, back end,
// restitution register and credit counters. Depends on dci_pkg, dci_front, dci_queue and dci_back.
//
// Usage:
//   Input side is a queue: drive a disk pair on the a_*/b_* ports with push;
//   the transaction is taken at a clock edge where push is high and full low.
//   Result side is a queue: while empty is low the oldest result sits on
//   a_new_vel_*, b_new_vel_* and outcome; pop high at an edge takes it.
//   Restitution (unsigned Q1.15) is written on the cfg_valid/cfg_ready
//   channel, ready always high; write it only while the block is idle.
// Timing:
//   One pair per cycle while full stays low. A result can be popped after its
//   input has passed two front stages, one queue slot, three
//   multiply stages, an overflow check and a 21-stage restoring divider with
//   one quotient bit per stage, then the write into the result queue.
// Reset (rst, synchronous): queues empty, restitution back to 0.9.
// Stall: when pop stays low, results gather in a 32-entry queue; credit
//   counters stop the back end and then raise full, and nothing is dropped.
`default_nettype none

module disk_collision_impulse (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic signed [dci_pkg::POS_W-1:0]   a_pos_x,
  input  logic signed [dci_pkg::POS_W-1:0]   a_pos_y,
  input  logic signed [dci_pkg::VEL_W-1:0]   a_vel_x,
  input  logic signed [dci_pkg::VEL_W-1:0]   a_vel_y,
  input  logic [dci_pkg::RAD_W-1:0]          a_radius,
  input  logic [dci_pkg::MASS_W-1:0]         a_mass,
  input  logic signed [dci_pkg::POS_W-1:0]   b_pos_x,
  input  logic signed [dci_pkg::POS_W-1:0]   b_pos_y,
  input  logic signed [dci_pkg::VEL_W-1:0]   b_vel_x,
  input  logic signed [dci_pkg::VEL_W-1:0]   b_vel_y,
  input  logic [dci_pkg::RAD_W-1:0]          b_radius,
  input  logic [dci_pkg::MASS_W-1:0]         b_mass,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [dci_pkg::VEL_W-1:0]   a_new_vel_x,
  output logic signed [dci_pkg::VEL_W-1:0]   a_new_vel_y,
  output logic signed [dci_pkg::VEL_W-1:0]   b_new_vel_x,
  output logic signed [dci_pkg::VEL_W-1:0]   b_new_vel_y,
  output logic [1:0]                         outcome,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dci_pkg::CFG_W-1:0]          restitution
);

  logic [dci_pkg::CFG_W-1:0]    restitution_reg;
  logic                         accept, front_valid, mid_valid, mid_pop, res_pop;
  dci_pkg::mid_t                front_item, mid_head;
  dci_pkg::result_t             res_head;
  logic [dci_pkg::MID_CW-1:0]   front_credit;
  logic [dci_pkg::OUT_CW-1:0]   back_credit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution_reg <= dci_pkg::RESTITUTION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      restitution_reg <= restitution;
    end
  end

  assign full    = front_credit >= dci_pkg::MID_CW'(dci_pkg::MID_DEPTH);
  assign accept  = push && !full;
  assign mid_pop = mid_valid && (back_credit < dci_pkg::OUT_CW'(dci_pkg::OUT_DEPTH));
  assign res_pop = pop && !empty;

  // front credit: items in the front stages or the queue
  // back credit: items in the back pipeline or the result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      front_credit <= '0;
      back_credit  <= '0;
    end else begin
      if (accept && !mid_pop) begin
        front_credit <= front_credit + 1'b1;
      end else if (mid_pop && !accept) begin
        front_credit <= front_credit - 1'b1;
      end
      if (mid_pop && !res_pop) begin
        back_credit <= back_credit + 1'b1;
      end else if (res_pop && !mid_pop) begin
        back_credit <= back_credit - 1'b1;
      end
    end
  end

  dci_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .a_pos_x   (a_pos_x),
    .a_pos_y   (a_pos_y),
    .a_vel_x   (a_vel_x),
    .a_vel_y   (a_vel_y),
    .a_radius  (a_radius),
    .a_mass    (a_mass),
    .b_pos_x   (b_pos_x),
    .b_pos_y   (b_pos_y),
    .b_vel_x   (b_vel_x),
    .b_vel_y   (b_vel_y),
    .b_radius  (b_radius),
    .b_mass    (b_mass),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  dci_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_item (front_item),
    .pop       (mid_pop),
    .valid     (mid_valid),
    .head      (mid_head)
  );

  dci_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (mid_pop),
    .in_item     (mid_head),
    .restitution (restitution_reg),
    .pop         (pop),
    .empty       (empty),
    .head        (res_head)
  );

  assign a_new_vel_x = res_head.avx;
  assign a_new_vel_y = res_head.avy;
  assign b_new_vel_x = res_head.bvx;
  assign b_new_vel_y = res_head.bvy;
  assign outcome     = res_head.outcome;

endmodule

`default_nettype wire

// File: hw/rtl/dci_checker.sv
// Port-level checks for disk_collision_impulse, attached by bind.
// Depends on dci_pkg widths and the top-level port list.
`default_nettype none

module dci_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic [dci_pkg::VEL_W-1:0]         a_new_vel_x,
  input logic [dci_pkg::VEL_W-1:0]         b_new_vel_y,
  input logic [1:0]                        outcome
);

  // a result cannot come through the whole pipeline right after reset, so empty stays high
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty ##1 empty ##1 empty)
    else $error("result appeared too soon after reset");

  a_not_full_after_reset: assert property (@(posedge clk)
    rst |=> !full)
    else $error("full asserted right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result transaction dropped");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(outcome) && $stable(a_new_vel_x) && $stable(b_new_vel_y))
    else $error("waiting result changed");

endmodule

bind disk_collision_impulse dci_checker u_dci_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .a_new_vel_x (a_new_vel_x),
  .b_new_vel_y (b_new_vel_y),
  .outcome     (outcome)
);

`default_nettype wire
